// ----- rtl/decimal_length_frame_deframer_core_defines.svh -----
// assertion macros shared by the deframer checker
`ifndef DECIMAL_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define DECIMAL_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DLFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DLFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- rtl/dlfd_pkg.sv -----
// types and constants for the decimal length frame deframer
package dlfd_pkg;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LEN      = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_TRAILER  = 3'd3,
    PH_FILEBODY = 3'd4
  } dlfd_phase_t;

  typedef enum logic [2:0] {
    EV_DATA     = 3'd0,
    EV_DONE     = 3'd1,
    EV_TRAILER  = 3'd2,
    EV_ABORT    = 3'd3,
    EV_LONG     = 3'd4,
    EV_FILE_END = 3'd5
  } dlfd_evt_t;

  typedef enum logic [1:0] {
    KIND_MSG  = 2'd0,
    KIND_NAME = 2'd1,
    KIND_BODY = 2'd2
  } dlfd_kind_t;

  localparam logic [7:0] CH_M  = 8'h6D;
  localparam logic [7:0] CH_F  = 8'h66;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;

  localparam int unsigned OUT_LEN_W  = 16;
  localparam int unsigned MAX_LEN_W  = 16;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'hFFFF;

  // one result of the parser, valid marks that the item produced one
  typedef struct packed {
    logic                 valid;
    logic [7:0]           data;
    dlfd_kind_t           kind;
    dlfd_evt_t            evt;
    logic [OUT_LEN_W-1:0] length;
    logic                 last;
  } dlfd_result_t;

endpackage

// ----- rtl/dlfd_parser.sv -----
// frame state machine: length digits, payload count, trailer check and file body
module dlfd_parser import dlfd_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic                 closed,
  input  logic [MAX_LEN_W-1:0] max_length,
  output dlfd_result_t         res
);

  localparam int ACC_W = LENGTH_BITS + 1;
  localparam int MUL_W = LENGTH_BITS + 5;
  localparam int CMP_W = (ACC_W > OUT_LEN_W) ? ACC_W : OUT_LEN_W;

  dlfd_phase_t            phase_r, phase_nxt;
  logic                   is_file_r, is_file_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] seen_r, seen_nxt;

  logic [MUL_W-1:0]       acc_x10;
  logic [LENGTH_BITS-1:0] seen_inc;
  logic [CMP_W-1:0]       acc_ext;
  logic [CMP_W-1:0]       max_ext;
  logic [3:0]             digit;
  dlfd_kind_t             hdr_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      is_file_r <= 1'b0;
      acc_r     <= '0;
      seen_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      is_file_r <= is_file_nxt;
      acc_r     <= acc_nxt;
      seen_r    <= seen_nxt;
    end
  end

  // times ten plus the digit by two shifts and two adds, saturating at 2^LENGTH_BITS
  assign digit    = 4'(rx_byte - CH_0);
  assign acc_x10  = MUL_W'({acc_r, 3'b000}) + MUL_W'({acc_r, 1'b0}) + MUL_W'(digit);
  assign seen_inc = seen_r + LENGTH_BITS'(1);
  assign acc_ext  = CMP_W'(acc_r);
  assign max_ext  = CMP_W'(max_length);
  assign hdr_kind = is_file_r ? KIND_NAME : KIND_MSG;

  always_comb begin
    phase_nxt   = phase_r;
    is_file_nxt = is_file_r;
    acc_nxt     = acc_r;
    seen_nxt    = seen_r;
    res         = '{valid: 1'b0, data: 8'h00, kind: hdr_kind, evt: EV_DATA,
                    length: '0, last: 1'b0};

    if (closed) begin
      phase_nxt   = PH_IDLE;
      is_file_nxt = 1'b0;
      acc_nxt     = '0;
      seen_nxt    = '0;
      case (phase_r)
        PH_LEN, PH_PAYLOAD: begin
          res.valid = 1'b1;
          res.evt   = EV_ABORT;
          res.last  = 1'b1;
        end
        PH_TRAILER: begin
          res.valid = 1'b1;
          res.kind  = KIND_MSG;
          res.evt   = EV_TRAILER;
          res.last  = 1'b1;
        end
        PH_FILEBODY: begin
          res.valid = 1'b1;
          res.kind  = KIND_BODY;
          res.evt   = EV_FILE_END;
          res.last  = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (rx_byte == CH_M || rx_byte == CH_F) begin
            phase_nxt   = PH_LEN;
            is_file_nxt = (rx_byte == CH_F);
            acc_nxt     = '0;
            seen_nxt    = '0;
          end
        end
        PH_LEN: begin
          if (rx_byte == CH_NL) begin
            if (acc_ext > max_ext) begin
              phase_nxt   = PH_IDLE;
              is_file_nxt = 1'b0;
              acc_nxt     = '0;
              seen_nxt    = '0;
              res.valid   = 1'b1;
              res.evt     = EV_LONG;
              res.last    = 1'b1;
            end else begin
              seen_nxt = '0;
              if (acc_r != '0) begin
                phase_nxt = PH_PAYLOAD;
              end else begin
                phase_nxt = is_file_r ? PH_FILEBODY : PH_TRAILER;
              end
            end
          end else if (rx_byte inside {[CH_0:CH_9]}) begin
            if (|acc_x10[MUL_W-1:LENGTH_BITS]) begin
              acc_nxt = {1'b1, {LENGTH_BITS{1'b0}}};
            end else begin
              acc_nxt = acc_x10[ACC_W-1:0];
            end
          end
        end
        PH_PAYLOAD: begin
          res.valid = 1'b1;
          res.data  = rx_byte;
          seen_nxt  = seen_inc;
          if ({1'b0, seen_inc} >= acc_r) begin
            phase_nxt = is_file_r ? PH_FILEBODY : PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          phase_nxt   = PH_IDLE;
          is_file_nxt = 1'b0;
          acc_nxt     = '0;
          seen_nxt    = '0;
          res.valid   = 1'b1;
          res.kind    = KIND_MSG;
          res.last    = 1'b1;
          if (rx_byte == CH_NL) begin
            res.evt    = EV_DONE;
            res.length = acc_ext[OUT_LEN_W-1:0];
          end else begin
            res.evt = EV_TRAILER;
          end
        end
        PH_FILEBODY: begin
          res.valid = 1'b1;
          res.data  = rx_byte;
          res.kind  = KIND_BODY;
        end
        default: begin
          phase_nxt   = PH_IDLE;
          is_file_nxt = 1'b0;
          acc_nxt     = '0;
          seen_nxt    = '0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/decimal_length_frame_deframer_core.sv -----
// top level of the decimal length prefixed frame deframer
//
//  channel   dir  handshake            contents
//  in_*      in   in_tvalid/in_tready   one received byte or a close event
//  out_*     out  out_tvalid/out_tready payload byte or frame event
//  cfg_*     in   cfg_wr_en             max_length register
//
// one item a cycle sustained: input register, one pass through the parser,
// result register; the result is valid once the item has passed both registers
// both stages stall while a result waits in the result register with out_tready low;
// an item with no result still needs the result stage free to move on
// rst_n is synchronous, active low: parser idle, max_length = 65535
module decimal_length_frame_deframer_core import dlfd_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] closed
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [23:8] out_length
  output logic [4:0]  out_tuser,  // [1:0] out_kind, [4:2] out_event
  output logic        out_tlast,  // is_last
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // input stage
  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_closed_r;

  // result stage
  logic         out_valid_r, out_valid_nxt;
  dlfd_result_t out_res_r;

  logic [MAX_LEN_W-1:0] max_len_r;

  dlfd_result_t res;
  logic         advance;
  logic         in_take;

  // the parser steps on an item when the result stage can take its output
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_len_r   <= MAX_LEN_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r   <= in_tdata;
      s1_closed_r <= in_tuser[0];
    end
    if (advance && res.valid) begin
      out_res_r <= res;
    end
  end

  dlfd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .rx_byte    (s1_byte_r),
    .closed     (s1_closed_r),
    .max_length (max_len_r),
    .res        (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.length, out_res_r.data};
  assign out_tuser  = {out_res_r.evt, out_res_r.kind};
  assign out_tlast  = out_res_r.last;

endmodule

// ----- rtl/dlfd_checker.sv -----
// port level checks for the deframer, bound to the top level
`include "decimal_length_frame_deframer_core_defines.svh"

module dlfd_checker import dlfd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [4:0]  out_tuser,
  input logic        out_tlast
);

  logic [29:0] out_word;
  logic [7:0]  out_byte;
  logic [15:0] out_len;
  logic [2:0]  out_evt;
  logic [1:0]  out_kind;
  logic        end_evt;
  logic [1:0]  end_kind;

  assign out_word = {out_tdata, out_tuser, out_tlast};
  assign out_byte = out_tdata[7:0];
  assign out_len  = out_tdata[23:8];
  assign out_evt  = out_tuser[4:2];
  assign out_kind = out_tuser[1:0];
  assign end_evt  = (out_evt == EV_DONE) || (out_evt == EV_TRAILER) || (out_evt == EV_FILE_END);
  assign end_kind = (out_evt == EV_FILE_END) ? KIND_BODY : KIND_MSG;

  // a stalled result holds
  `DLFD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word))

  // data items never close a frame and carry no length
  `DLFD_ASSERT_NOW(a_data_shape, out_tvalid && out_evt == EV_DATA, !out_tlast && out_len == '0)

  // frame events close the frame and carry no byte
  `DLFD_ASSERT_NOW(a_event_shape, out_tvalid && out_evt != EV_DATA, out_tlast && out_byte == '0)

  // message ends are tagged as message, file end as file content
  `DLFD_ASSERT_NOW(a_end_kind, out_tvalid && end_evt, out_kind == end_kind)

endmodule

bind decimal_length_frame_deframer_core dlfd_checker u_dlfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
